@@ hw/rtl/dslr_pkg.sv @@
// Shared types and constants for the double slot line receiver.
package dslr_pkg;

    localparam logic       OP_BYTE = 1'b0;
    localparam logic       OP_READ = 1'b1;
    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_LF   = 8'h0a;
    localparam logic [7:0] CH_CR   = 8'h0d;

    typedef struct packed {
        logic start;
        logic ready;
        logic nonempty;
    } t_rd_req;

    typedef struct packed {
        logic busy;
        logic release_slot;
    } t_rd_rsp;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_EMPTY  = 3'b010,
        S_STREAM = 3'b100
    } t_rd_state;

endpackage

@@ hw/rtl/double_slot_line_receiver_unit.sv @@
// Top level of the double slot line receiver: byte assembly, slot bookkeeping and line reads.
// A received byte transaction can be taken every cycle while o_stall is low.
// A read transaction holds o_stall high while the line streams out: the reader first issues
// the read of the line's first character from the line RAM, then passes one character per
// cycle through its single read port whenever the output is not stalled; a read that finds
// no ready line returns one result with o_found low. Lines live in one RAM of
// SLOT_COUNT*LINE_BYTES bytes that needs no clearing after reset; only written positions
// are ever read back.
module double_slot_line_receiver_unit
    import dslr_pkg::*;
#(
    parameter int LINE_BYTES = 64,
    parameter int SLOT_COUNT = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_op,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_found,
    output logic [7:0] o_line_byte,
    output logic       o_last
);

    localparam int SW    = $clog2(SLOT_COUNT);
    localparam int BW    = $clog2(LINE_BYTES);
    localparam int DEPTH = SLOT_COUNT * LINE_BYTES;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [SW-1:0] SLOT_LAST   = SW'(SLOT_COUNT - 1);
    localparam logic [BW-1:0] LEN_MAX     = BW'(LINE_BYTES - 1);
    localparam logic [AW-1:0] LINE_STRIDE = AW'(LINE_BYTES);

    logic [SLOT_COUNT-1:0] r_ready, n_ready;
    logic [BW-1:0]         r_len_tab [SLOT_COUNT];
    logic [BW-1:0]         n_len_tab [SLOT_COUNT];
    logic [SW-1:0]         r_wslot, n_wslot;
    logic [SW-1:0]         r_rslot, n_rslot;
    logic [BW-1:0]         r_wlen, n_wlen;
    logic                  r_wovf, n_wovf;

    logic          acc_byte;
    logic          acc_read;
    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    logic          mem_rd_en;
    logic [AW-1:0] mem_rd_addr;
    logic [7:0]    mem_rd_data;
    t_rd_req       rd_req;
    t_rd_rsp       rd_rsp;

    function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
        next_slot = (s == SLOT_LAST) ? '0 : s + 1'b1;
    endfunction

    assign o_stall  = rd_rsp.busy;
    assign acc_byte = i_valid && !o_stall && (i_op == OP_BYTE) && (i_rx_byte != CH_NUL);
    assign acc_read = i_valid && !o_stall && (i_op == OP_READ);

    always_comb begin
        logic [SW-1:0] w;
        logic [SW-1:0] nx;
        logic [BW-1:0] len;
        logic          ovf;
        logic          drop;
        w           = r_wslot;
        nx          = '0;
        len         = r_wlen;
        ovf         = r_wovf;
        drop        = 1'b0;
        n_ready     = r_ready;
        n_len_tab   = r_len_tab;
        n_rslot     = r_rslot;
        mem_wr_en   = 1'b0;
        mem_wr_addr = '0;
        if (acc_byte) begin
            if (r_ready[w]) begin
                nx = next_slot(w);
                if (r_ready[nx]) begin
                    drop = 1'b1;
                end else begin
                    w   = nx;
                    len = '0;
                    ovf = 1'b0;
                end
            end
            if (!drop) begin
                if (i_rx_byte == CH_CR || i_rx_byte == CH_LF) begin
                    if (len != '0) begin
                        n_ready[w]   = 1'b1;
                        n_len_tab[w] = len;
                        nx = next_slot(w);
                        if (!r_ready[nx]) begin
                            w   = nx;
                            len = '0;
                            ovf = 1'b0;
                        end
                    end
                end else if (!ovf) begin
                    if (len < LEN_MAX) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = AW'(w) * LINE_STRIDE + AW'(len);
                        len         = len + 1'b1;
                    end else begin
                        ovf = 1'b1;
                    end
                end
            end
        end
        if (rd_rsp.release_slot) begin
            n_ready[r_rslot] = 1'b0;
            n_rslot          = next_slot(r_rslot);
            if (r_rslot == r_wslot) begin
                len = '0;
                ovf = 1'b0;
            end
        end
        n_wslot = w;
        n_wlen  = len;
        n_wovf  = ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= '0;
            r_wslot <= '0;
            r_rslot <= '0;
            r_wlen  <= '0;
            r_wovf  <= 1'b0;
            for (int s = 0; s < SLOT_COUNT; s++) begin
                r_len_tab[s] <= '0;
            end
        end else begin
            r_ready   <= n_ready;
            r_wslot   <= n_wslot;
            r_rslot   <= n_rslot;
            r_wlen    <= n_wlen;
            r_wovf    <= n_wovf;
            r_len_tab <= n_len_tab;
        end
    end

    assign rd_req.start    = acc_read;
    assign rd_req.ready    = r_ready[r_rslot];
    assign rd_req.nonempty = (r_len_tab[r_rslot] != '0);

    dslr_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (i_rx_byte),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    dslr_reader #(
        .LINE_BYTES (LINE_BYTES),
        .SLOT_COUNT (SLOT_COUNT)
    ) u_reader (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (rd_req),
        .i_slot      (r_rslot),
        .i_len       (r_len_tab[r_rslot]),
        .o_rsp       (rd_rsp),
        .o_rd_en     (mem_rd_en),
        .o_rd_addr   (mem_rd_addr),
        .i_rd_data   (mem_rd_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_found     (o_found),
        .o_line_byte (o_line_byte),
        .o_last      (o_last)
    );

    a_release_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_rsp.release_slot |-> r_ready[r_rslot])
        else $error("Slot released while not ready.");

    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_read |=> rd_rsp.busy)
        else $error("Read transaction accepted without the reader going busy.");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wovf |-> (r_wlen == LEN_MAX))
        else $error("Overflow flag set on a line that is not full.");

    a_no_write_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_rsp.busy |-> !mem_wr_en)
        else $error("Line RAM written while a line is being read.");

endmodule

@@ hw/rtl/dslr_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
module dslr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/dslr_reader.sv @@
// Line read sequencer: streams one stored line from the RAM into the output register, or reports that none is ready.
module dslr_reader
    import dslr_pkg::*;
#(
    parameter int LINE_BYTES = 64,
    parameter int SLOT_COUNT = 2
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  t_rd_req                                   i_req,
    input  logic [$clog2(SLOT_COUNT)-1:0]             i_slot,
    input  logic [$clog2(LINE_BYTES)-1:0]             i_len,
    output t_rd_rsp                                   o_rsp,
    output logic                                      o_rd_en,
    output logic [$clog2(SLOT_COUNT*LINE_BYTES)-1:0]  o_rd_addr,
    input  logic [7:0]                                i_rd_data,
    output logic                                      o_valid,
    input  logic                                      i_stall,
    output logic                                      o_found,
    output logic [7:0]                                o_line_byte,
    output logic                                      o_last
);

    localparam int SW = $clog2(SLOT_COUNT);
    localparam int BW = $clog2(LINE_BYTES);
    localparam int AW = $clog2(SLOT_COUNT * LINE_BYTES);
    localparam logic [AW-1:0] LINE_STRIDE = AW'(LINE_BYTES);

    t_rd_state       r_state, n_state;
    logic [SW-1:0]   r_slot, n_slot;
    logic [BW-1:0]   r_len, n_len;
    logic [BW-1:0]   r_idx, n_idx;
    logic            r_hit, n_hit;
    logic            r_out_valid, n_out_valid;
    logic            r_out_found, n_out_found;
    logic [7:0]      r_out_byte, n_out_byte;
    logic            r_out_last, n_out_last;
    logic            out_free;
    logic            at_last;

    function automatic logic [AW-1:0] line_addr(input logic [SW-1:0] slot,
                                                input logic [BW-1:0] idx);
        line_addr = AW'(slot) * LINE_STRIDE + AW'(idx);
    endfunction

    assign out_free = !r_out_valid || !i_stall;
    assign at_last  = (r_idx == r_len - 1'b1);

    always_comb begin
        n_state     = r_state;
        n_slot      = r_slot;
        n_len       = r_len;
        n_idx       = r_idx;
        n_hit       = r_hit;
        n_out_valid = r_out_valid && i_stall;
        n_out_found = r_out_found;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        o_rd_en     = 1'b0;
        o_rd_addr   = line_addr(i_slot, '0);
        o_rsp.busy  = (r_state != S_IDLE);
        o_rsp.release_slot = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_req.start) begin
                    n_slot = i_slot;
                    n_len  = i_len;
                    n_idx  = '0;
                    n_hit  = i_req.ready;
                    if (i_req.ready && i_req.nonempty) begin
                        o_rd_en = 1'b1;
                        n_state = S_STREAM;
                    end else begin
                        n_state = S_EMPTY;
                    end
                end
            end
            S_EMPTY: begin
                if (out_free) begin
                    n_out_valid        = 1'b1;
                    n_out_found        = r_hit;
                    n_out_byte         = '0;
                    n_out_last         = 1'b1;
                    o_rsp.release_slot = r_hit;
                    n_state            = S_IDLE;
                end
            end
            S_STREAM: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_found = 1'b1;
                    n_out_byte  = i_rd_data;
                    n_out_last  = at_last;
                    if (at_last) begin
                        o_rsp.release_slot = 1'b1;
                        n_state            = S_IDLE;
                    end else begin
                        n_idx     = r_idx + 1'b1;
                        o_rd_en   = 1'b1;
                        o_rd_addr = line_addr(r_slot, r_idx + 1'b1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_slot      <= n_slot;
        r_len       <= n_len;
        r_idx       <= n_idx;
        r_hit       <= n_hit;
        r_out_found <= n_out_found;
        r_out_byte  <= n_out_byte;
        r_out_last  <= n_out_last;
    end

    assign o_valid     = r_out_valid;
    assign o_found     = r_out_found;
    assign o_line_byte = r_out_byte;
    assign o_last      = r_out_last;

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the double slot line receiver unit.
module testbench;
    import dslr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_BYTES  = 64;
    localparam int SLOT_COUNT  = 2;
    localparam int CLK_PERIOD  = 12;
    localparam int RESET_LEN   = 6;
    localparam int PHASE_ITEMS = 115;
    localparam int DRAIN_WAIT  = 16;
    localparam int CYCLE_LIMIT = 300000;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
    } t_rx_item;

    typedef struct packed {
        logic       found;
        logic [7:0] line_byte;
        logic       last;
    } t_line_char;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic       i_op = OP_BYTE;
    logic [7:0] i_rx_byte = CH_NUL;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic       o_found;
    logic [7:0] o_line_byte;
    logic       o_last;

    t_rx_item   pending_items[$];
    t_line_char line_chars_due[$];

    int src_idle_pct = 37;
    int snk_idle_pct = 77;
    int cycle_count = 0;
    int fail_count = 0;

    logic [7:0]  line_mem [SLOT_COUNT*LINE_BYTES];
    int unsigned line_len [SLOT_COUNT] = '{default: 0};
    bit          line_rdy [SLOT_COUNT] = '{default: 1'b0};
    bit          line_ovf [SLOT_COUNT] = '{default: 1'b0};
    int unsigned wr_slot = 0;
    int unsigned rd_slot = 0;

    double_slot_line_receiver_unit #(
        .LINE_BYTES(LINE_BYTES),
        .SLOT_COUNT(SLOT_COUNT)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_op       (i_op),
        .i_rx_byte  (i_rx_byte),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_found    (o_found),
        .o_line_byte(o_line_byte),
        .o_last     (o_last)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic int unsigned next_of(int unsigned s);
        return (s + 1) % SLOT_COUNT;
    endfunction

    function automatic void claim_slot(int unsigned s);
        wr_slot = s;
        line_len[s] = 0;
        line_ovf[s] = 1'b0;
    endfunction

    task automatic flag_error(input string msg);
        fail_count++;
        if (fail_count <= REPORT_MAX) begin
            $display("ERROR at cycle %0d: %s", cycle_count, msg);
        end
    endtask

    task automatic predict_transaction(input logic op, input logic [7:0] c);
        int unsigned w;
        int unsigned n;
        int unsigned r;
        bit          keep;
        keep = 1'b1;
        if (op == OP_BYTE) begin
            w = wr_slot;
            if (c == CH_NUL) begin
                keep = 1'b0;
            end else if (line_rdy[w]) begin
                n = next_of(w);
                if (line_rdy[n]) begin
                    keep = 1'b0;
                end else begin
                    claim_slot(n);
                    w = n;
                end
            end
            if (keep) begin
                if (c == CH_CR || c == CH_LF) begin
                    if (line_len[w] > 0) begin
                        line_rdy[w] = 1'b1;
                        n = next_of(w);
                        if (!line_rdy[n]) begin
                            claim_slot(n);
                        end
                    end
                end else if (!line_ovf[w]) begin
                    if (line_len[w] < LINE_BYTES - 1) begin
                        line_mem[w*LINE_BYTES + line_len[w]] = c;
                        line_len[w]++;
                    end else begin
                        line_ovf[w] = 1'b1;
                    end
                end
            end
        end else begin
            r = rd_slot;
            if (!line_rdy[r]) begin
                line_chars_due.push_back('{1'b0, CH_NUL, 1'b1});
            end else begin
                if (line_len[r] == 0) begin
                    line_chars_due.push_back('{1'b1, CH_NUL, 1'b1});
                end else begin
                    for (int i = 0; i < line_len[r]; i++) begin
                        line_chars_due.push_back('{1'b1, line_mem[r*LINE_BYTES + i],
                                                   (i + 1 == line_len[r])});
                    end
                end
                line_len[r] = 0;
                line_rdy[r] = 1'b0;
                line_ovf[r] = 1'b0;
                rd_slot = next_of(r);
            end
        end
    endtask

    // A transaction that is stalled keeps valid and its payload unchanged.
    always @(posedge i_clk) begin
        if (i_rst_n && !(i_valid && o_stall)) begin
            if (i_valid) begin
                void'(pending_items.pop_front());
            end
            if (pending_items.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                i_valid   <= 1'b1;
                i_op      <= pending_items[0].op;
                i_rx_byte <= pending_items[0].rx_byte;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        i_stall <= i_rst_n && ($urandom_range(99) < snk_idle_pct);
    end

    always @(posedge i_clk) begin
        t_line_char want;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                predict_transaction(i_op, i_rx_byte);
            end
            if (o_valid && !i_stall) begin
                if (line_chars_due.size() == 0) begin
                    flag_error($sformatf("unexpected result found=%0d byte=%02h last=%0d",
                                         o_found, o_line_byte, o_last));
                end else begin
                    want = line_chars_due.pop_front();
                    if (o_found !== want.found || o_line_byte !== want.line_byte ||
                        o_last !== want.last) begin
                        flag_error($sformatf(
                            "expected found=%0d byte=%02h last=%0d, got found=%0d byte=%02h last=%0d",
                            want.found, want.line_byte, want.last,
                            o_found, o_line_byte, o_last));
                    end
                end
            end
        end
    end

    task automatic queue_item(input logic op, input logic [7:0] c);
        pending_items.push_back('{op, c});
    endtask

    function automatic logic [7:0] text_char();
        logic [7:0] c;
        c = 8'($urandom_range(1, 255));
        while (c == CH_CR || c == CH_LF) begin
            c = 8'($urandom_range(1, 255));
        end
        return c;
    endfunction

    // Builds one line; a NUL now and then inside it must be skipped by the block.
    task automatic queue_line(input int len);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(15) == 0) begin
                queue_item(OP_BYTE, CH_NUL);
            end
            queue_item(OP_BYTE, text_char());
        end
        queue_item(OP_BYTE, $urandom_range(1) ? CH_CR : CH_LF);
    endtask

    task automatic queue_random_phase();
        int n;
        int sel;
        int len;
        len = $urandom_range(62, 70);
        queue_line(len);
        n = len + 1;
        while (n < PHASE_ITEMS) begin
            sel = $urandom_range(99);
            if (sel < 45) begin
                len = ($urandom_range(19) == 0) ? $urandom_range(55, 70) : $urandom_range(1, 8);
                queue_line(len);
                n += len + 1;
            end else if (sel < 80) begin
                queue_item(OP_READ, 8'($urandom));
                n++;
            end else begin
                case ($urandom_range(3))
                    0: queue_item(OP_BYTE, CH_NUL);
                    1: queue_item(OP_BYTE, CH_CR);
                    2: queue_item(OP_BYTE, CH_LF);
                    default: queue_item(OP_BYTE, 8'($urandom));
                endcase
                n++;
            end
        end
    endtask

    // Checked at the falling edge so that every rising-edge update has settled.
    task automatic wait_drained();
        while (pending_items.size() != 0 || line_chars_due.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("double_slot_line_receiver_unit test failed");
        $finish;
    end

    initial begin
        repeat (RESET_LEN) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_item(OP_READ, 8'hff);
        queue_item(OP_BYTE, CH_NUL);
        queue_item(OP_BYTE, CH_CR);
        queue_item(OP_BYTE, CH_LF);
        queue_item(OP_BYTE, 8'h01);
        queue_item(OP_BYTE, 8'hff);
        queue_item(OP_BYTE, 8'h80);
        queue_item(OP_BYTE, 8'h7f);
        queue_item(OP_BYTE, CH_CR);
        queue_item(OP_READ, CH_CR);
        queue_item(OP_BYTE, 8'h41);
        queue_item(OP_BYTE, CH_LF);
        queue_item(OP_BYTE, 8'h42);
        queue_item(OP_BYTE, CH_CR);
        queue_item(OP_BYTE, 8'h43);
        queue_item(OP_BYTE, CH_CR);
        queue_item(OP_READ, 8'h00);
        queue_item(OP_BYTE, 8'h44);
        queue_item(OP_READ, 8'h55);
        queue_item(OP_BYTE, CH_LF);
        queue_item(OP_READ, 8'haa);
        queue_item(OP_READ, 8'h00);
        queue_random_phase();
        wait_drained();

        src_idle_pct <= 77;
        snk_idle_pct <= 37;
        queue_random_phase();
        wait_drained();

        src_idle_pct <= 0;
        snk_idle_pct <= 0;
        queue_random_phase();
        wait_drained();

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (line_chars_due.size() != 0) begin
            flag_error($sformatf("%0d results never arrived", line_chars_due.size()));
        end
        if (fail_count == 0) begin
            $display("double_slot_line_receiver_unit test passed");
        end else begin
            $display("double_slot_line_receiver_unit test failed");
        end
        $finish;
    end

endmodule
